/* rtl/core/recursive_lock_fifo_handoff_defines.svh */
// ----------------------------------------------------------------------------
// Recursive lock assertion macros
// Shared assertion macros for the recursive lock; they compile away
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_LOCK_FIFO_HANDOFF_DEFINES_SVH
`define RECURSIVE_LOCK_FIFO_HANDOFF_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RLFH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("recursive lock: same-cycle check failed");
`define RLFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("recursive lock: next-cycle check failed");
`else
`define RLFH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLFH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/rlfh_pkg.sv */
// ----------------------------------------------------------------------------
// Recursive lock package
// Operation and status codes, field widths and the control structures
// exchanged between the lock controller and the wait queue.
// ----------------------------------------------------------------------------
package rlfh_pkg;

    localparam int OP_W     = 2;
    localparam int REQ_W    = 8;
    localparam int STATUS_W = 4;
    localparam int NEST_W   = 7;

    localparam logic [OP_W-1:0] OP_TRY     = 2'd0;
    localparam logic [OP_W-1:0] OP_OBTAIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_GRANTED   = 4'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_HELD      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_FREED     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_HANDED    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 4'd6;
    localparam logic [STATUS_W-1:0] ST_QFULL     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NEST_OVF  = 4'd8;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

/* rtl/core/recursive_lock_fifo_handoff.sv */
// ----------------------------------------------------------------------------
// Recursive lock with FIFO hand-off
// Top level: request register, lock controller and wait queue.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge at which start is high and busy is
// low; busy is high only while reset is applied, so one request per cycle is
// accepted. Each request gives exactly one result, shown for a single cycle
// with o_done once it has passed through the request register and then
// through the decision logic into the ownership and status registers.
// Results cannot be held off, so the receiver must take each one in the
// cycle it appears. The head of the wait queue is read from its memory
// into a register in advance, which keeps every request a single pass.
module recursive_lock_fifo_handoff
    import rlfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_NEST    = 127,
    parameter int ID_BITS     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [REQ_W-1:0]    i_requester,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [REQ_W-1:0]    o_new_owner,
    output logic                o_owned,
    output logic [NEST_W-1:0]   o_nest_level
);

`include "recursive_lock_fifo_handoff_defines.svh"

    localparam int ID_W = (ID_BITS < REQ_W) ? ID_BITS : REQ_W;

    logic            r_req_valid;
    logic [OP_W-1:0] r_op;
    logic [ID_W-1:0] r_who;
    t_q_ctrl         q_ctrl;
    t_q_stat         q_stat;
    logic [ID_W-1:0] head_id;
    logic [ID_W-1:0] owner_id;

    assign busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= i_op;
        r_who <= i_requester[ID_W-1:0];
    end

    rlfh_ctrl #(
        .MAX_NEST (MAX_NEST),
        .ID_W     (ID_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (r_req_valid),
        .i_op         (r_op),
        .i_who        (r_who),
        .i_q_stat     (q_stat),
        .i_head_id    (head_id),
        .o_q_ctrl     (q_ctrl),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_owned      (o_owned),
        .o_owner_id   (owner_id),
        .o_nest_level (o_nest_level)
    );

    rlfh_waitq #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (ID_W)
    ) u_waitq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (q_ctrl),
        .i_push_id (r_who),
        .o_stat    (q_stat),
        .o_head_id (head_id)
    );

    assign o_new_owner = REQ_W'(owner_id);

    `RLFH_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, r_req_valid, o_done)
    `RLFH_ASSERT_NEXT(a_no_stray_result, i_clk, i_rst_n, !r_req_valid, !o_done)
    `RLFH_ASSERT_IMP(a_handoff_count, i_clk, i_rst_n, o_done && (o_status == ST_HANDED), o_owned && (o_nest_level == NEST_W'(1)))
    `RLFH_ASSERT_IMP(a_error_keeps_state, i_clk, i_rst_n, o_done && ((o_status == ST_NOT_OWNER) || (o_status == ST_QFULL) || (o_status == ST_NEST_OVF)), $stable(o_owned) && $stable(o_new_owner) && $stable(o_nest_level))

endmodule

/* rtl/core/rlfh_waitq.sv */
// ----------------------------------------------------------------------------
// Recursive lock wait queue
// Circular buffer of waiting requester ids with a registered read of the
// head entry, bypassed when the head is written in the same cycle.
// ----------------------------------------------------------------------------
module rlfh_waitq import rlfh_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int ID_W  = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_q_ctrl         i_ctrl,
    input  logic [ID_W-1:0] i_push_id,
    output t_q_stat         o_stat,
    output logic [ID_W-1:0] o_head_id
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_W-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ID_W-1:0]  r_head_id;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_tail  = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            n_head  = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_push_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && (r_tail == n_head)) begin
            r_head_id <= i_push_id;
        end else begin
            r_head_id <= r_mem[n_head];
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_head_id    = r_head_id;

endmodule

/* rtl/core/rlfh_ctrl.sv */
// ----------------------------------------------------------------------------
// Recursive lock controller
// Decides each request against the owner, nesting count and queue state,
// and holds the ownership registers and the registered status.
// ----------------------------------------------------------------------------
module rlfh_ctrl import rlfh_pkg::*; #(
    parameter int MAX_NEST = 127,
    parameter int ID_W     = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ID_W-1:0]     i_who,
    input  t_q_stat             i_q_stat,
    input  logic [ID_W-1:0]     i_head_id,
    output t_q_ctrl             o_q_ctrl,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_owned,
    output logic [ID_W-1:0]     o_owner_id,
    output logic [NEST_W-1:0]   o_nest_level
);

    logic                r_owned, n_owned;
    logic [ID_W-1:0]     r_owner_id, n_owner_id;
    logic [NEST_W-1:0]   r_nest, n_nest;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_done;
    logic                free_or_mine;
    logic                nest_ovf;

    assign free_or_mine = !r_owned || (r_owner_id == i_who);
    assign nest_ovf     = r_owned && (r_nest >= NEST_W'(MAX_NEST));

    always_comb begin
        n_owned    = r_owned;
        n_owner_id = r_owner_id;
        n_nest     = r_nest;
        n_status   = r_status;
        o_q_ctrl   = '0;
        if (i_req_valid) begin
            unique case (i_op)
                OP_TRY, OP_OBTAIN: begin
                    if (free_or_mine) begin
                        if (nest_ovf) begin
                            n_status = ST_NEST_OVF;
                        end else begin
                            n_owned    = 1'b1;
                            n_owner_id = i_who;
                            n_nest     = r_nest + 1'b1;
                            n_status   = ST_GRANTED;
                        end
                    end else if (i_op == OP_TRY) begin
                        n_status = ST_REFUSED;
                    end else if (i_q_stat.full) begin
                        n_status = ST_QFULL;
                    end else begin
                        o_q_ctrl.push = 1'b1;
                        n_status      = ST_QUEUED;
                    end
                end
                OP_RELEASE: begin
                    if (!r_owned || (r_owner_id != i_who)) begin
                        n_status = ST_NOT_OWNER;
                    end else if (r_nest > NEST_W'(1)) begin
                        n_nest   = r_nest - 1'b1;
                        n_status = ST_HELD;
                    end else if (!i_q_stat.empty) begin
                        o_q_ctrl.pop = 1'b1;
                        n_owner_id   = i_head_id;
                        n_nest       = NEST_W'(1);
                        n_status     = ST_HANDED;
                    end else begin
                        n_owned    = 1'b0;
                        n_owner_id = '0;
                        n_nest     = '0;
                        n_status   = ST_FREED;
                    end
                end
                default: begin
                    n_status = ST_REFUSED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owned    <= 1'b0;
            r_owner_id <= '0;
            r_nest     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_owned    <= n_owned;
            r_owner_id <= n_owner_id;
            r_nest     <= n_nest;
            r_done     <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_owned      = r_owned;
    assign o_owner_id   = r_owner_id;
    assign o_nest_level = r_nest;

endmodule
